// ----- rtl/core/rcam_pkg.sv -----
// Shared types and constants of the rounded corner alpha mask unit.
// Holds the item structs, the configuration struct and the register indexes.
// Depends on nothing; every other file of the block uses it.
package rcam_pkg;

	localparam int COORD_BITS = 12;
	localparam int GEO_BITS = ((COORD_BITS + 2 > 15) ? COORD_BITS + 2 : 15) + 1;

	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS = 13;

	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 4'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ARC_RADIUS   = 4'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_ALPHA   = 4'd3;

	localparam logic [12:0] FRAME_WIDTH_RESET  = 13'd640;
	localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd480;
	localparam logic [10:0] ARC_RADIUS_RESET   = 11'd8;
	localparam logic [7:0]  BASE_ALPHA_RESET   = 8'd200;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
		logic [7:0]            in_blue;
		logic [7:0]            in_green;
		logic [7:0]            in_red;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic [7:0] out_alpha;
	} out_item_t;

	typedef struct packed {
		logic [12:0] frame_width;
		logic [12:0] frame_height;
		logic [10:0] arc_radius;
		logic [7:0]  base_alpha;
	} cfg_t;

	typedef struct packed {
		logic                       black;
		logic                       corner;
		logic signed [GEO_BITS-1:0] dx;
		logic signed [GEO_BITS-1:0] dy;
		logic [7:0]                 blue;
		logic [7:0]                 green;
		logic [7:0]                 red;
	} cls_item_t;

endpackage

// ----- rtl/core/rcam_front.sv -----
// Front classifier: finds the corner a pixel falls in and its offset from the corner centre.
// Uses rcam_pkg for the item and configuration structs.
module rcam_front (
	input  rcam_pkg::in_item_t  pixel,
	input  rcam_pkg::cfg_t      cfg,
	output rcam_pkg::cls_item_t cls
);

	localparam int C = rcam_pkg::COORD_BITS;
	localparam int GW = rcam_pkg::GEO_BITS;

	logic signed [GW-1:0] x2, y2, r2, wr2, hr2, cx, cy;
	logic left, right, top, bottom;

	always_comb begin
		x2 = $signed({{(GW-C-1){1'b0}}, pixel.pixel_x, 1'b1});
		y2 = $signed({{(GW-C-1){1'b0}}, pixel.pixel_y, 1'b1});
		r2 = $signed({{(GW-12){1'b0}}, cfg.arc_radius, 1'b0});
		wr2 = $signed({{(GW-14){1'b0}}, cfg.frame_width, 1'b0}) - r2;
		hr2 = $signed({{(GW-14){1'b0}}, cfg.frame_height, 1'b0}) - r2;
		left = x2 < r2;
		right = x2 > wr2;
		top = y2 < r2;
		bottom = y2 > hr2;
		cx = left ? r2 - GW'(1) : wr2 - GW'(1);
		cy = top ? r2 - GW'(1) : hr2 - GW'(1);
		cls.black = (pixel.in_blue == 8'd0) && (pixel.in_green == 8'd0)
			&& (pixel.in_red == 8'd0);
		cls.corner = (left || right) && (top || bottom);
		cls.dx = x2 - cx;
		cls.dy = y2 - cy;
		cls.blue = pixel.in_blue;
		cls.green = pixel.in_green;
		cls.red = pixel.in_red;
	end

endmodule

// ----- rtl/core/rcam_queue.sv -----
// Short queue of classified items between the front classifier and the back pipeline.
// Uses rcam_pkg for the item struct and the queue depth.
module rcam_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  rcam_pkg::cls_item_t wr_item,
	output logic                full,
	input  logic                rd_en,
	output rcam_pkg::cls_item_t rd_item,
	output logic                empty
);

	localparam int DEPTH = rcam_pkg::QUEUE_DEPTH;
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rcam_pkg::cls_item_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_wr, do_rd;

	assign full = count_q == CW'(DEPTH);
	assign empty = count_q == '0;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// ----- rtl/core/rcam_back.sv -----
// Back pipeline: squared distance, ramp numerator and an eight stage restoring divider.
// Uses rcam_pkg for the item and configuration structs.
module rcam_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rcam_pkg::cfg_t      cfg,
	input  logic                in_valid,
	input  rcam_pkg::cls_item_t in_item,
	output logic                in_take,
	output logic                empty,
	input  logic                pop,
	output rcam_pkg::out_item_t result
);

	localparam int GW = rcam_pkg::GEO_BITS;
	localparam int SQW = 2 * GW;
	localparam int DW = SQW + 1;
	localparam int RW = 24;
	localparam int DIFFW = 14;
	localparam int NW = 24;
	localparam int QB = 8;

	typedef struct packed {
		logic           black;
		logic           corner;
		logic [SQW-1:0] sq_x;
		logic [SQW-1:0] sq_y;
		logic [RW-1:0]  rm;
		logic [RW-1:0]  rp;
		logic [23:0]    color;
	} s1_t;

	typedef struct packed {
		logic             use_div;
		logic [7:0]       pre_alpha;
		logic [DIFFW-1:0] diff;
		logic [23:0]      color;
	} s2_t;

	typedef struct packed {
		logic          use_div;
		logic [7:0]    pre_alpha;
		logic [NW-1:0] rem;
		logic [QB-1:0] quo;
		logic [23:0]   color;
	} div_t;

	s1_t p_s1, p_s1_d;
	s2_t p_s2, p_s2_d;
	div_t div_s [QB+1];
	div_t div_d [QB+1];
	logic vld_s1, vld_s2;
	logic div_vld_s [QB+1];
	logic adv_s1, adv_s2;
	logic div_adv [QB+1];
	logic [NW-1:0] den;

	assign den = {{(NW-15){1'b0}}, cfg.arc_radius, 4'b0000};

	always_comb begin
		div_adv[QB] = !div_vld_s[QB] || pop;
		for (int k = QB - 1; k >= 0; k--) begin
			div_adv[k] = !div_vld_s[k] || div_adv[k+1];
		end
		adv_s2 = !vld_s2 || div_adv[0];
		adv_s1 = !vld_s1 || adv_s2;
	end

	assign in_take = in_valid && adv_s1;

	logic signed [12:0] rm_base;
	logic signed [2*GW-1:0] sqx_full, sqy_full;
	logic signed [25:0] rm_full;
	logic [23:0] rp_full;

	always_comb begin
		rm_base = $signed({1'b0, cfg.arc_radius, 1'b0}) - 13'sd1;
		sqx_full = in_item.dx * in_item.dx;
		sqy_full = in_item.dy * in_item.dy;
		rm_full = rm_base * rm_base;
		rp_full = {cfg.arc_radius, 1'b1} * {cfg.arc_radius, 1'b1};
		p_s1_d.black = in_item.black;
		p_s1_d.corner = in_item.corner;
		p_s1_d.sq_x = SQW'(unsigned'(sqx_full));
		p_s1_d.sq_y = SQW'(unsigned'(sqy_full));
		p_s1_d.rm = rm_full[RW-1:0];
		p_s1_d.rp = rp_full;
		p_s1_d.color = {in_item.blue, in_item.green, in_item.red};
	end

	logic [DW-1:0] dsq;
	logic [RW-1:0] rp_diff;
	logic in_full, in_zero;

	always_comb begin
		dsq = {1'b0, p_s1.sq_x} + {1'b0, p_s1.sq_y};
		in_full = dsq <= {{(DW-RW){1'b0}}, p_s1.rm};
		in_zero = dsq >= {{(DW-RW){1'b0}}, p_s1.rp};
		rp_diff = p_s1.rp - dsq[RW-1:0];
		p_s2_d.diff = rp_diff[DIFFW-1:0];
		p_s2_d.color = p_s1.color;
		p_s2_d.use_div = 1'b0;
		if (!p_s1.black) begin
			p_s2_d.pre_alpha = 8'd255;
		end else if (!p_s1.corner || in_full) begin
			p_s2_d.pre_alpha = cfg.base_alpha;
		end else if (in_zero) begin
			p_s2_d.pre_alpha = 8'd0;
		end else begin
			p_s2_d.pre_alpha = 8'd0;
			p_s2_d.use_div = 1'b1;
		end
	end

	logic [22:0] num_prod;

	always_comb begin
		num_prod = {cfg.base_alpha, 1'b0} * p_s2.diff;
		div_d[0].use_div = p_s2.use_div;
		div_d[0].pre_alpha = p_s2.pre_alpha;
		div_d[0].rem = {1'b0, num_prod} + {{(NW-14){1'b0}}, cfg.arc_radius, 3'b000};
		div_d[0].quo = '0;
		div_d[0].color = p_s2.color;
	end

	for (genvar k = 1; k <= QB; k++) begin : g_div
		localparam int B = QB - k;
		logic [NW-1:0] trial;
		always_comb begin
			trial = den << B;
			div_d[k] = div_s[k-1];
			if (div_s[k-1].rem >= trial) begin
				div_d[k].rem = div_s[k-1].rem - trial;
				div_d[k].quo[B] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int k = 0; k <= QB; k++) begin
				div_vld_s[k] <= 1'b0;
			end
		end else begin
			if (adv_s1) begin
				vld_s1 <= in_valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
			if (div_adv[0]) begin
				div_vld_s[0] <= vld_s2;
			end
			for (int k = 1; k <= QB; k++) begin
				if (div_adv[k]) begin
					div_vld_s[k] <= div_vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			p_s1 <= p_s1_d;
		end
		if (adv_s2) begin
			p_s2 <= p_s2_d;
		end
		for (int k = 0; k <= QB; k++) begin
			if (div_adv[k]) begin
				div_s[k] <= div_d[k];
			end
		end
	end

	assign empty = !div_vld_s[QB];
	assign result.out_blue = div_s[QB].color[23:16];
	assign result.out_green = div_s[QB].color[15:8];
	assign result.out_red = div_s[QB].color[7:0];
	assign result.out_alpha = div_s[QB].use_div ? div_s[QB].quo : div_s[QB].pre_alpha;

endmodule

// ----- rtl/core/rounded_corner_alpha_mask_unit.sv -----
// Top level of the rounded corner alpha mask unit: configuration registers and the two halves.
// Depends on rcam_pkg, rcam_front, rcam_queue and rcam_back.
//
// The unit turns a stream of pixels into premultiplied color and alpha for a window with
// rounded, antialiased corners. It takes one pixel per clock cycle for as long as results
// are taken. Each pixel passes through the input queue, the squared distance register, the
// compare register, the ramp numerator register and the eight divider stages, which
// resolve one quotient bit per stage. The configuration port is always ready; write it
// only while no pixel is in flight.
module rounded_corner_alpha_mask_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  rcam_pkg::in_item_t                    pixel,
	output logic                                  empty,
	input  logic                                  pop,
	output rcam_pkg::out_item_t                   result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rcam_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [rcam_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	rcam_pkg::cfg_t cfg_q;
	rcam_pkg::cls_item_t cls, head;
	logic head_empty, head_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width <= rcam_pkg::FRAME_WIDTH_RESET;
			cfg_q.frame_height <= rcam_pkg::FRAME_HEIGHT_RESET;
			cfg_q.arc_radius <= rcam_pkg::ARC_RADIUS_RESET;
			cfg_q.base_alpha <= rcam_pkg::BASE_ALPHA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rcam_pkg::REG_FRAME_WIDTH: begin
					cfg_q.frame_width <= cfg_data[12:0];
				end
				rcam_pkg::REG_FRAME_HEIGHT: begin
					cfg_q.frame_height <= cfg_data[12:0];
				end
				rcam_pkg::REG_ARC_RADIUS: begin
					cfg_q.arc_radius <= cfg_data[10:0];
				end
				rcam_pkg::REG_BASE_ALPHA: begin
					cfg_q.base_alpha <= cfg_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	rcam_front u_front (
		.pixel (pixel),
		.cfg   (cfg_q),
		.cls   (cls)
	);

	rcam_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_item (cls),
		.full    (full),
		.rd_en   (head_take),
		.rd_item (head),
		.empty   (head_empty)
	);

	rcam_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (!head_empty),
		.in_item  (head),
		.in_take  (head_take),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

// ----- verif/rcam_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the rounded corner alpha mask unit: predicts every pixel item and checks results.
// Depends on rcam_pkg; instantiated by the testbench top beside the unit.
module rcam_checker
	import rcam_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic                      full,
	input  in_item_t                  pixel,
	input  logic                      empty,
	input  logic                      pop,
	input  out_item_t                 result,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output int                        mismatch_count,
	output int                        pending_pixels
);

	cfg_t live_cfg = '{FRAME_WIDTH_RESET, FRAME_HEIGHT_RESET, ARC_RADIUS_RESET,
		BASE_ALPHA_RESET};
	out_item_t expected_pixels[$];
	out_item_t want;
	int fails;

	function automatic out_item_t shade_pixel(in_item_t p, cfg_t c);
		longint px, py, x2, y2, w, h, r, a, cx, cy, dx, dy, d, rm, rp, den, alpha;
		logic left, right, top, bottom;
		out_item_t o;
		px = longint'(p.pixel_x);
		py = longint'(p.pixel_y);
		w = longint'(c.frame_width);
		h = longint'(c.frame_height);
		r = longint'(c.arc_radius);
		a = longint'(c.base_alpha);
		x2 = 2 * px + 1;
		y2 = 2 * py + 1;
		left = x2 < 2 * r;
		right = x2 > 2 * (w - r);
		top = y2 < 2 * r;
		bottom = y2 > 2 * (h - r);
		alpha = a;
		if ((left || right) && (top || bottom)) begin
			cx = left ? (2 * r - 1) : (2 * (w - r) - 1);
			cy = top ? (2 * r - 1) : (2 * (h - r) - 1);
			dx = x2 - cx;
			dy = y2 - cy;
			d = dx * dx + dy * dy;
			rm = (2 * r - 1) * (2 * r - 1);
			rp = (2 * r + 1) * (2 * r + 1);
			if (d <= rm) begin
				alpha = a;
			end else if (d >= rp) begin
				alpha = 0;
			end else begin
				den = 8 * r;
				alpha = (2 * a * (rp - d) + den) / (2 * den);
			end
		end
		if (p.in_blue == 8'd0 && p.in_green == 8'd0 && p.in_red == 8'd0) begin
			o = '{8'd0, 8'd0, 8'd0, alpha[7:0]};
		end else begin
			o = '{p.in_blue, p.in_green, p.in_red, 8'd255};
		end
		return o;
	endfunction

	function automatic int field_differs(string name, logic [7:0] exp_val, logic [7:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0d, actual %0d", name, exp_val, act_val);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_cfg <= '{FRAME_WIDTH_RESET, FRAME_HEIGHT_RESET, ARC_RADIUS_RESET,
				BASE_ALPHA_RESET};
			expected_pixels.delete();
			pending_pixels <= 0;
			mismatch_count <= 0;
		end else begin
			fails = 0;
			if (pop && !empty) begin
				if (expected_pixels.size() == 0) begin
					$error("result item %h arrived with no pixel waiting", result);
					fails++;
				end else begin
					want = expected_pixels.pop_front();
					fails += field_differs("out_blue", want.out_blue, result.out_blue);
					fails += field_differs("out_green", want.out_green, result.out_green);
					fails += field_differs("out_red", want.out_red, result.out_red);
					fails += field_differs("out_alpha", want.out_alpha, result.out_alpha);
				end
			end
			if (push && !full) begin
				expected_pixels.push_back(shade_pixel(pixel, live_cfg));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_WIDTH: live_cfg.frame_width <= cfg_data;
					REG_FRAME_HEIGHT: live_cfg.frame_height <= cfg_data;
					REG_ARC_RADIUS: live_cfg.arc_radius <= cfg_data[10:0];
					REG_BASE_ALPHA: live_cfg.base_alpha <= cfg_data[7:0];
					default: ;
				endcase
			end
			pending_pixels <= expected_pixels.size();
			mismatch_count <= mismatch_count + fails;
		end
	end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Testbench top of the rounded corner alpha mask unit: clock, reset, pixel and register stimulus.
// Depends on rcam_pkg, rounded_corner_alpha_mask_unit and rcam_checker, which does the checking.
module testbench;
	import rcam_pkg::*;

	localparam logic [CFG_INDEX_BITS-1:0] UNMAPPED_REG = 4'd11;
	localparam int SETTLE_CYCLES = 20;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_PIXELS = 230;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_item_t pixel = '0;
	logic empty;
	logic pop = 1'b0;
	out_item_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	int mismatch_count;
	int pending_pixels;
	int stall_cycles = 0;
	logic no_idle = 1'b0;
	int aim_width = 640;
	int aim_height = 480;
	int aim_radius = 8;

	rounded_corner_alpha_mask_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .pixel(pixel),
		.empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	rcam_checker scoreboard (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .pixel(pixel),
		.empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatch_count(mismatch_count), .pending_pixels(pending_pixels)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		pop <= arst_n && (no_idle || $urandom_range(99) >= 26);
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic in_item_t pix(int x, int y, int b, int g, int r);
		in_item_t p;
		p.pixel_x = COORD_BITS'(x);
		p.pixel_y = COORD_BITS'(y);
		p.in_blue = 8'(b);
		p.in_green = 8'(g);
		p.in_red = 8'(r);
		return p;
	endfunction

	function automatic int clip_coord(int v);
		if (v < 0) return 0;
		if (v > 4095) return 4095;
		return v;
	endfunction

	// Most pixels land near a corner of the current shape so that the ramp is hit often.
	function automatic in_item_t random_pixel();
		int span, x, y, mode;
		logic [23:0] color;
		span = 2 * aim_radius + 2;
		mode = $urandom_range(99);
		if (mode < 60) begin
			x = $urandom_range(1) ? $urandom_range(span) : aim_width - 1 - $urandom_range(span);
			y = $urandom_range(1) ? $urandom_range(span) : aim_height - 1 - $urandom_range(span);
		end else if (mode < 75) begin
			x = $urandom_range(4095);
			y = aim_height + $urandom_range(8) - 4;
		end else begin
			x = $urandom_range(4095);
			y = $urandom_range(4095);
		end
		color = 24'($urandom);
		if ($urandom_range(99) < 70) begin
			color = '0;
		end else if (color == '0) begin
			color = 24'd1;
		end
		return pix(clip_coord(x), clip_coord(y), color[23:16], color[15:8], color[7:0]);
	endfunction

	task automatic send_pixel(input in_item_t p);
		logic taken;
		while (!no_idle && $urandom_range(99) < 26) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		pixel <= p;
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
	endtask

	// Leaves the sender quiet until every result is back, then lets the pipeline run dry.
	task automatic drain();
		push <= 1'b0;
		do @(negedge clk); while (pending_pixels != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		logic taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic run_phase(input int w, input int h, input int r, input int a,
		input logic quiet, input logic spare);
		drain();
		no_idle = quiet;
		aim_width = w & 13'h1FFF;
		aim_height = h & 13'h1FFF;
		aim_radius = r & 11'h7FF;
		@(posedge clk);
		write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(w));
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(h));
		write_reg(REG_ARC_RADIUS, CFG_DATA_BITS'(r));
		write_reg(REG_BASE_ALPHA, CFG_DATA_BITS'(a));
		if (spare) begin
			write_reg(UNMAPPED_REG, CFG_DATA_BITS'($urandom));
		end
		cfg_valid <= 1'b0;
		for (int i = 0; i < PHASE_PIXELS; i++) begin
			send_pixel(random_pixel());
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset shape: 640 by 480, radius 8, base alpha 200.
		send_pixel(pix(0, 0, 0, 0, 0));
		send_pixel(pix(7, 7, 0, 0, 0));
		send_pixel(pix(0, 4, 0, 0, 0));
		send_pixel(pix(4, 0, 0, 0, 0));
		send_pixel(pix(1, 1, 0, 0, 0));
		send_pixel(pix(2, 2, 0, 0, 0));
		send_pixel(pix(639, 0, 0, 0, 0));
		send_pixel(pix(0, 479, 0, 0, 0));
		send_pixel(pix(639, 479, 0, 0, 0));
		send_pixel(pix(635, 475, 0, 0, 0));
		send_pixel(pix(320, 240, 0, 0, 0));
		send_pixel(pix(4095, 4095, 0, 0, 0));
		send_pixel(pix(4095, 0, 0, 0, 0));
		send_pixel(pix(0, 4095, 0, 0, 0));
		send_pixel(pix(700, 500, 0, 0, 0));
		send_pixel(pix(0, 0, 255, 255, 255));
		send_pixel(pix(1, 1, 1, 0, 0));
		send_pixel(pix(2, 2, 0, 1, 0));
		send_pixel(pix(3, 3, 0, 0, 1));
		send_pixel(pix(4095, 4095, 128, 64, 32));
		send_pixel(pix(320, 240, 255, 0, 0));

		for (int i = 0; i < PHASE_PIXELS; i++) begin
			if (i == PHASE_PIXELS / 2) begin
				drain();
				@(posedge clk);
			end
			send_pixel(random_pixel());
		end

		// The radius exceeds half of both sizes here, so left and top corners win.
		run_phase(1, 1, 4, 255, 1'b0, 1'b0);
		run_phase(4096, 4096, 1024, 255, 1'b1, 1'b0);
		run_phase(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 1'b0, 1'b0);
		run_phase(100, 60, 0, 0, 1'b0, 1'b0);
		run_phase(64, 40, 1, 77, 1'b0, 1'b0);
		run_phase(0, 0, 5, 180, 1'b0, 1'b1);
		run_phase(320, 200, 16, 1, 1'b0, 1'b0);

		drain();
		if (mismatch_count == 0 && pending_pixels == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
